/* rtl/lfsc_pkg.sv */
// Package for the line follower steering controller.
// Holds the tracking state type, the code constants and the drive scaling function.
// No dependencies; lfsc_step, the core and the testbench import it.
`default_nettype none

package lfsc_pkg;

  localparam int unsigned NUM_SENSORS = 5;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_THR_ZERO  = 3'd0;
  localparam logic [2:0] REG_THR_ONE   = 3'd1;
  localparam logic [2:0] REG_THR_TWO   = 3'd2;
  localparam logic [2:0] REG_THR_THREE = 3'd3;
  localparam logic [2:0] REG_THR_FOUR  = 3'd4;
  localparam logic [2:0] REG_MASTER    = 3'd5;

  localparam logic [7:0] THR_ZERO_RST  = 8'd128;
  localparam logic [7:0] THR_ONE_RST   = 8'd180;
  localparam logic [7:0] THR_TWO_RST   = 8'd76;
  localparam logic [7:0] THR_THREE_RST = 8'd76;
  localparam logic [7:0] THR_FOUR_RST  = 8'd180;
  localparam logic [7:0] MASTER_RST    = 8'd230;

  // Remembered turn direction.
  localparam logic [1:0] DIR_NONE     = 2'd0;
  localparam logic [1:0] DIR_RIGHT    = 2'd1;
  localparam logic [1:0] DIR_LEFT     = 2'd2;
  localparam logic [1:0] DIR_STRAIGHT = 2'd3;

  // Loop tracking phase.
  localparam logic [1:0] PHASE_OUT  = 2'd0;
  localparam logic [1:0] PHASE_IN   = 2'd2;
  localparam logic [1:0] PHASE_EXIT = 2'd3;

  localparam logic [15:0] TICK_LIMIT = 16'hFFFE;
  localparam logic [7:0]  LED_MASK   = 8'hE0;

  // Motor direction codes on port bits 0-3.
  localparam logic [7:0] PORT_FWD   = 8'h0A;
  localparam logic [7:0] PORT_LEFT  = 8'h06;
  localparam logic [7:0] PORT_RIGHT = 8'h09;

  // Sensor patterns, bit i set when sensor i sees the line.
  localparam logic [4:0] PAT_C      = 5'h04;
  localparam logic [4:0] PAT_CL     = 5'h08;
  localparam logic [4:0] PAT_CR     = 5'h02;
  localparam logic [4:0] PAT_RC     = 5'h06;
  localparam logic [4:0] PAT_LC     = 5'h0C;
  localparam logic [4:0] PAT_ALL    = 5'h1F;
  localparam logic [4:0] PAT_L3     = 5'h1C;
  localparam logic [4:0] PAT_L4     = 5'h1E;
  localparam logic [4:0] PAT_L2     = 5'h18;
  localparam logic [4:0] PAT_L1     = 5'h10;
  localparam logic [4:0] PAT_R3     = 5'h07;
  localparam logic [4:0] PAT_R4     = 5'h0F;
  localparam logic [4:0] PAT_R2     = 5'h03;
  localparam logic [4:0] PAT_R1     = 5'h01;
  localparam logic [4:0] PAT_WIDE   = 5'h0E;

  // Percent scale factors: ceil(P * 2^16 / 100). With an 8-bit master level the
  // error stays below 1/256, so the top byte of the product is floor(m * P / 100).
  localparam logic [15:0] K_65 = 16'd42599;
  localparam logic [15:0] K_70 = 16'd45876;
  localparam logic [15:0] K_75 = 16'd49152;
  localparam logic [15:0] K_80 = 16'd52429;

  typedef logic [NUM_SENSORS-1:0][7:0] lfsc_bytes_t;

  typedef struct packed {
    logic [4:0]  last_pattern;
    logic [1:0]  last_direction;
    logic [1:0]  loop_phase;
    logic [15:0] fine_ticks;
    logic [15:0] mid_ticks;
    logic [15:0] coarse_ticks;
    logic [7:0]  square_count;
    logic [7:0]  best_ticks;
    logic [7:0]  best_square;
    logic [7:0]  display_value;
    logic [7:0]  port_reg;
    logic [7:0]  right_reg;
    logic [7:0]  left_reg;
    logic        halt_flag;
  } lfsc_state_t;

  localparam lfsc_state_t STATE_RESET = '{
    last_pattern:   5'd0,
    last_direction: DIR_NONE,
    loop_phase:     PHASE_OUT,
    fine_ticks:     16'd0,
    mid_ticks:      16'd0,
    coarse_ticks:   16'd0,
    square_count:   8'd0,
    best_ticks:     8'd0,
    best_square:    8'd0,
    display_value:  8'd0,
    port_reg:       8'd0,
    right_reg:      8'hFF,
    left_reg:       8'hFF,
    halt_flag:      1'b0
  };

  function automatic logic [7:0] pct_scale(input logic [7:0] level, input logic [15:0] k);
    logic [23:0] prod;
    prod = {16'd0, level} * {8'd0, k};
    return prod[23:16];
  endfunction

  // LED field: low three bits of a value placed on port bits 5-7.
  function automatic logic [7:0] led_bits(input logic [7:0] v);
    return {v[2:0], 5'd0};
  endfunction

endpackage

`default_nettype wire

/* rtl/lfsc_if.sv */
// Channel interfaces of the line follower steering controller.
// lfsc_in_if carries one sensor sweep, lfsc_out_if one result; valid/ready handshake.
// No dependencies.
`default_nettype none

interface lfsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] sample_zero;
  logic [7:0] sample_one;
  logic [7:0] sample_two;
  logic [7:0] sample_three;
  logic [7:0] sample_four;

  modport source (
    output valid, sample_zero, sample_one, sample_two, sample_three, sample_four,
    input  ready
  );
  modport sink (
    input  valid, sample_zero, sample_one, sample_two, sample_three, sample_four,
    output ready
  );
endinterface

interface lfsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] port_value;
  logic [7:0] right_drive;
  logic [7:0] left_drive;
  logic       stopped;

  modport source (
    output valid, port_value, right_drive, left_drive, stopped,
    input  ready
  );
  modport sink (
    input  valid, port_value, right_drive, left_drive, stopped,
    output ready
  );
endinterface

`default_nettype wire

/* rtl/lfsc_step.sv */
// Next-state logic for one sensor sweep: thresholding, tick counters, loop tracking,
// halt test and steering decode. Purely combinational; depends on lfsc_pkg.
`default_nettype none

module lfsc_step
  import lfsc_pkg::*;
(
  input  wire lfsc_bytes_t samples,
  input  wire lfsc_bytes_t thresholds,
  input  wire logic [7:0]  full_scale,
  input  wire lfsc_state_t st_i,
  output lfsc_state_t      st_o
);

  logic [4:0]  pat;
  lfsc_state_t s;
  logic        drv;
  logic        set_dir;
  logic [7:0]  port_v;
  logic [15:0] kr;
  logic [15:0] kl;
  logic [1:0]  dir_v;

  always_comb begin
    for (int i = 0; i < NUM_SENSORS; i++) begin
      pat[i] = samples[i] > thresholds[i];
    end
  end

  always_comb begin
    s       = st_i;
    drv     = 1'b0;
    set_dir = 1'b0;
    port_v  = PORT_FWD;
    kr      = K_80;
    kl      = K_80;
    dir_v   = DIR_STRAIGHT;

    if (!st_i.halt_flag) begin
      // Cascaded tick counters run only inside the loop.
      if (s.loop_phase == PHASE_IN) begin
        s.fine_ticks = s.fine_ticks + 16'd1;
      end
      if (s.fine_ticks >= TICK_LIMIT) begin
        s.mid_ticks  = s.mid_ticks + 16'd1;
        s.fine_ticks = 16'd0;
      end
      if (s.mid_ticks >= TICK_LIMIT) begin
        s.coarse_ticks = s.coarse_ticks + 16'd1;
        s.mid_ticks    = 16'd0;
        s.fine_ticks   = 16'd0;
      end

      if (s.loop_phase == PHASE_EXIT) begin
        s.loop_phase = PHASE_OUT;
        s.port_reg   = s.port_reg | led_bits(s.display_value);
      end
      if (s.loop_phase == PHASE_OUT) begin
        s.display_value = s.square_count;
        s.port_reg      = s.port_reg | led_bits(s.display_value);
      end

      if (s.last_pattern == PAT_ALL && pat == PAT_ALL) begin
        // Second all-black sweep: show the best square and stop for good.
        s.port_reg      = led_bits(s.best_square);
        s.display_value = s.best_square;
        s.halt_flag     = 1'b1;
      end else if (s.last_pattern != pat) begin
        case (pat)
          PAT_C, PAT_CL, PAT_CR: begin
            drv = 1'b1; set_dir = 1'b1;
          end
          PAT_RC: begin
            drv = 1'b1; set_dir = 1'b1; kr = K_75; dir_v = DIR_RIGHT;
          end
          PAT_LC: begin
            drv = 1'b1; set_dir = 1'b1; kl = K_75; dir_v = DIR_LEFT;
          end
          PAT_ALL: begin
            // Node: toggles loop tracking, drives straight with the LEDs lit.
            if (s.loop_phase == PHASE_OUT) begin
              s.loop_phase = PHASE_IN;
            end else if (s.loop_phase == PHASE_IN) begin
              s.loop_phase = PHASE_EXIT;
              if ({8'd0, s.best_ticks} <= s.coarse_ticks) begin
                s.best_square = s.square_count + 8'd2;
                s.best_ticks  = s.coarse_ticks[7:0];
              end
              s.display_value = s.square_count + 8'd1;
              s.square_count  = s.square_count + 8'd1;
              s.coarse_ticks  = 16'd0;
              s.fine_ticks    = 16'd0;
            end
            drv    = 1'b1;
            port_v = PORT_FWD | LED_MASK;
          end
          PAT_L3, PAT_L4: begin
            drv = 1'b1; set_dir = 1'b1; port_v = PORT_LEFT; kl = K_65; dir_v = DIR_LEFT;
          end
          PAT_L2, PAT_L1: begin
            drv = 1'b1; set_dir = 1'b1; port_v = PORT_LEFT; kr = K_70; dir_v = DIR_LEFT;
          end
          PAT_R3, PAT_R4: begin
            drv = 1'b1; set_dir = 1'b1; port_v = PORT_RIGHT; kr = K_65; dir_v = DIR_RIGHT;
          end
          PAT_R2, PAT_R1: begin
            drv = 1'b1; set_dir = 1'b1; port_v = PORT_RIGHT; kl = K_70; dir_v = DIR_RIGHT;
          end
          PAT_WIDE: begin
            // Wide center: turn again in the remembered direction, if one is remembered.
            if (s.last_direction == DIR_RIGHT) begin
              drv = 1'b1; set_dir = 1'b1; port_v = PORT_RIGHT; kl = K_70; dir_v = DIR_RIGHT;
            end else if (s.last_direction == DIR_LEFT) begin
              drv = 1'b1; set_dir = 1'b1; port_v = PORT_LEFT; kr = K_70; dir_v = DIR_LEFT;
            end
          end
          default: begin
          end
        endcase

        if (drv) begin
          s.port_reg  = port_v;
          s.right_reg = pct_scale(full_scale, kr);
          s.left_reg  = pct_scale(full_scale, kl);
        end
        if (set_dir) begin
          s.last_direction = dir_v;
        end
        s.last_pattern = pat;
      end
    end
  end

  assign st_o = s;

endmodule

`default_nettype wire

/* rtl/line_follower_steering_controller_core.sv */
// Top level of the line follower steering controller.
// Holds the configuration, input, state and result registers; depends on lfsc_pkg,
// lfsc_if (channel interfaces) and lfsc_step (per-sweep next-state logic).
`default_nettype none

// Each input transaction is one sweep of five 8-bit sensor samples. Every sample is
// compared with its own threshold register (strictly greater means line), and the
// resulting 5-bit pattern steers the motors: direction bits go to port bits 0-3, and
// the right and left drive values are the full-scale drive level scaled by 65, 70, 75
// or 80 percent, truncated. The block also tracks loops between all-black nodes with
// cascaded tick counters and counts squares; the square count or the best square shows
// on port bits 5-7. Two all-black sweeps in a row stop the block for good: from then on
// every sweep returns the held outputs with stopped set. Each input transaction yields
// exactly one result transaction. A sweep is captured in an input register, processed
// in one pass of combinational logic and written to the result register together with
// the tracking state once the result register is free or being drained, so a sweep
// passes the input register and then the result register. One sweep can be taken every
// cycle while the receiver keeps ready high; the single state update per cycle sets
// that rate. The input side keeps accepting while a result waits, up to one sweep held
// in the input register. Configuration writes (thresholds at indexes 0-4, the full-scale
// drive level at index 5; other indexes are ignored) take effect at once and should be
// made only while no sweep is in flight.

module line_follower_steering_controller_core
  import lfsc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  lfsc_in_if.sink         in_ch,
  lfsc_out_if.source      out_ch,
  input  wire logic       cfg_we,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  lfsc_bytes_t thr_r;
  logic [7:0]  master_r;

  // Input register.
  logic        s1_v_r;
  lfsc_bytes_t s1_samp_r;
  logic        s1_fire;

  // Tracking state.
  lfsc_state_t state_r;
  lfsc_state_t state_nxt;

  // Result register.
  logic        out_v_r;
  logic [7:0]  out_port_r;
  logic [7:0]  out_right_r;
  logic [7:0]  out_left_r;
  logic        out_stop_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r[0] <= THR_ZERO_RST;
      thr_r[1] <= THR_ONE_RST;
      thr_r[2] <= THR_TWO_RST;
      thr_r[3] <= THR_THREE_RST;
      thr_r[4] <= THR_FOUR_RST;
      master_r <= MASTER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_THR_ZERO:  thr_r[0] <= cfg_data;
        REG_THR_ONE:   thr_r[1] <= cfg_data;
        REG_THR_TWO:   thr_r[2] <= cfg_data;
        REG_THR_THREE: thr_r[3] <= cfg_data;
        REG_THR_FOUR:  thr_r[4] <= cfg_data;
        REG_MASTER:    master_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // The held sweep moves on whenever the result register is free or being drained.
  assign s1_fire     = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !s1_v_r || s1_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_samp_r[0] <= in_ch.sample_zero;
      s1_samp_r[1] <= in_ch.sample_one;
      s1_samp_r[2] <= in_ch.sample_two;
      s1_samp_r[3] <= in_ch.sample_three;
      s1_samp_r[4] <= in_ch.sample_four;
    end
  end

  lfsc_step u_step (
    .samples    (s1_samp_r),
    .thresholds (thr_r),
    .full_scale (master_r),
    .st_i       (state_r),
    .st_o       (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STATE_RESET;
    end else if (s1_fire) begin
      state_r <= state_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (s1_fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_port_r  <= state_nxt.port_reg;
      out_right_r <= state_nxt.right_reg;
      out_left_r  <= state_nxt.left_reg;
      out_stop_r  <= state_nxt.halt_flag;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.port_value  = out_port_r;
  assign out_ch.right_drive = out_right_r;
  assign out_ch.left_drive  = out_left_r;
  assign out_ch.stopped     = out_stop_r;

endmodule

`default_nettype wire

/* tb/tb_line_follower_steering_controller_core.sv */
// Testbench for line_follower_steering_controller_core.
// Uses lfsc_pkg and the lfsc_in_if / lfsc_out_if channel interfaces. A built-in
// steering predictor checks every result transaction while the stimulus runs.

module tb_line_follower_steering_controller_core;
  import lfsc_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int CYCLE_LIMIT  = 200000;
  // A sweep passes the input register and then the result register, so quiet cycles
  // after the last result show that nothing else is on its way.
  localparam int SETTLE_CYCLES = 6;
  localparam int ITEMS_PER_SETTING = 230;

  // Drive percentages of full scale.
  localparam int PCT_65 = 65;
  localparam int PCT_70 = 70;
  localparam int PCT_75 = 75;
  localparam int PCT_80 = 80;

  // Idle modes: percent of cycles in which the sender idles / the receiver stalls.
  localparam int MODE_STEADY   = 0;
  localparam int MODE_SENDER   = 1;
  localparam int MODE_RECEIVER = 2;
  localparam int MODE_BOTH     = 3;

  localparam logic [2:0] THR_REG [5] = '{REG_THR_ZERO, REG_THR_ONE, REG_THR_TWO,
                                         REG_THR_THREE, REG_THR_FOUR};

  // Every pattern with a steering decode, except the all-black node.
  localparam logic [4:0] STEER_PATS [14] = '{PAT_C, PAT_CL, PAT_CR, PAT_RC, PAT_LC,
                                             PAT_L3, PAT_L4, PAT_L2, PAT_L1, PAT_R3,
                                             PAT_R4, PAT_R2, PAT_R1, PAT_WIDE};

  typedef struct packed {
    logic [7:0] port_value;
    logic [7:0] right_drive;
    logic [7:0] left_drive;
    logic       stopped;
  } steer_result_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [2:0] cfg_index;
  logic [7:0] cfg_data;

  lfsc_in_if  in_ch ();
  lfsc_out_if out_ch ();

  line_follower_steering_controller_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Predictor copy of the configuration and of the tracking state.
  logic [7:0]    line_level [5];
  logic [7:0]    drive_level;
  lfsc_state_t   steer_state;
  steer_result_t expected_steer [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Sensor i reads as line only when its sample is strictly above its level.
  function automatic logic [4:0] line_pattern(input lfsc_bytes_t s);
    logic [4:0] p;
    p = '0;
    for (int i = 0; i < 5; i++) begin
      if (s[i] > line_level[i]) p[i] = 1'b1;
    end
    return p;
  endfunction

  // Truncated percentage of the master drive level.
  function automatic logic [7:0] scaled_drive(input int percent);
    return 8'((int'(drive_level) * percent) / 100);
  endfunction

  function automatic void steer(input logic [7:0] port, input int right_pct,
                                input int left_pct, input logic [1:0] dir);
    steer_state.port_reg       = port;
    steer_state.right_reg      = scaled_drive(right_pct);
    steer_state.left_reg       = scaled_drive(left_pct);
    steer_state.last_direction = dir;
  endfunction

  function automatic void show_leds(input logic [7:0] v);
    steer_state.port_reg = steer_state.port_reg | {v[2:0], 5'b0};
  endfunction

  // Advances the predictor by one sweep and returns the result it must produce.
  function automatic steer_result_t predict_steer(input lfsc_bytes_t s);
    logic [4:0]    pat;
    steer_result_t r;
    if (!steer_state.halt_flag) begin
      pat = line_pattern(s);

      // Cascaded loop timers; only the fine counter runs by itself.
      if (steer_state.loop_phase == PHASE_IN)
        steer_state.fine_ticks = steer_state.fine_ticks + 16'd1;
      if (steer_state.fine_ticks >= TICK_LIMIT) begin
        steer_state.mid_ticks  = steer_state.mid_ticks + 16'd1;
        steer_state.fine_ticks = '0;
      end
      if (steer_state.mid_ticks >= TICK_LIMIT) begin
        steer_state.coarse_ticks = steer_state.coarse_ticks + 16'd1;
        steer_state.mid_ticks    = '0;
        steer_state.fine_ticks   = '0;
      end

      // Leaving the loop shows the new count once, then the display follows
      // the square count while outside the loop.
      if (steer_state.loop_phase == PHASE_EXIT) begin
        steer_state.loop_phase = PHASE_OUT;
        show_leds(steer_state.display_value);
      end
      if (steer_state.loop_phase == PHASE_OUT) begin
        steer_state.display_value = steer_state.square_count;
        show_leds(steer_state.display_value);
      end

      if (steer_state.last_pattern == PAT_ALL && pat == PAT_ALL) begin
        // Second node in a row: stop for good and show the best square.
        steer_state.port_reg      = '0;
        steer_state.display_value = steer_state.best_square;
        show_leds(steer_state.display_value);
        steer_state.halt_flag     = 1'b1;
      end else if (steer_state.last_pattern != pat) begin
        case (pat)
          PAT_C, PAT_CL, PAT_CR: steer(PORT_FWD, PCT_80, PCT_80, DIR_STRAIGHT);
          PAT_RC:                steer(PORT_FWD, PCT_75, PCT_80, DIR_RIGHT);
          PAT_LC:                steer(PORT_FWD, PCT_80, PCT_75, DIR_LEFT);
          PAT_ALL: begin
            if (steer_state.loop_phase == PHASE_OUT) begin
              steer_state.loop_phase = PHASE_IN;
            end else if (steer_state.loop_phase == PHASE_IN) begin
              steer_state.loop_phase = PHASE_EXIT;
              if ({8'd0, steer_state.best_ticks} <= steer_state.coarse_ticks) begin
                steer_state.best_square = steer_state.square_count + 8'd2;
                steer_state.best_ticks  = steer_state.coarse_ticks[7:0];
              end
              steer_state.display_value = steer_state.square_count + 8'd1;
              steer_state.square_count  = steer_state.square_count + 8'd1;
              steer_state.coarse_ticks  = '0;
              steer_state.fine_ticks    = '0;
            end
            // A node drives straight at full LEDs but keeps the remembered turn.
            steer_state.port_reg  = PORT_FWD | LED_MASK;
            steer_state.right_reg = scaled_drive(PCT_80);
            steer_state.left_reg  = scaled_drive(PCT_80);
          end
          PAT_L3, PAT_L4: steer(PORT_LEFT, PCT_80, PCT_65, DIR_LEFT);
          PAT_L2, PAT_L1: steer(PORT_LEFT, PCT_70, PCT_80, DIR_LEFT);
          PAT_R3, PAT_R4: steer(PORT_RIGHT, PCT_65, PCT_80, DIR_RIGHT);
          PAT_R2, PAT_R1: steer(PORT_RIGHT, PCT_80, PCT_70, DIR_RIGHT);
          PAT_WIDE: begin
            // A wide centre reading repeats the last turn, if there was one.
            if (steer_state.last_direction == DIR_RIGHT)
              steer(PORT_RIGHT, PCT_80, PCT_70, DIR_RIGHT);
            else if (steer_state.last_direction == DIR_LEFT)
              steer(PORT_LEFT, PCT_70, PCT_80, DIR_LEFT);
          end
          default: ;
        endcase
        steer_state.last_pattern = pat;
      end
    end
    r.port_value  = steer_state.port_reg;
    r.right_drive = steer_state.right_reg;
    r.left_drive  = steer_state.left_reg;
    r.stopped     = steer_state.halt_flag;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Builds samples that give the wanted pattern under the current levels. Values
  // right at a level and one above it are favored, as are the field extremes.
  // A sensor whose level is 255 can never read as line.
  function automatic lfsc_bytes_t sweep_for(input logic [4:0] want);
    lfsc_bytes_t s;
    int          pick;
    for (int i = 0; i < 5; i++) begin
      pick = $urandom_range(3);
      if (want[i] && line_level[i] != 8'hFF) begin
        if (pick == 0)      s[i] = line_level[i] + 8'd1;
        else if (pick == 1) s[i] = 8'hFF;
        else                s[i] = 8'($urandom_range(255, int'(line_level[i]) + 1));
      end else begin
        if (pick == 0)      s[i] = line_level[i];
        else if (pick == 1) s[i] = 8'h00;
        else                s[i] = 8'($urandom_range(int'(line_level[i]), 0));
      end
    end
    return s;
  endfunction

  // Mostly well-formed steering and node sequences, with some raw noise. A sweep
  // that would make a second node in a row gets sensor 0 forced dark, since the
  // halt is permanent and is exercised only at the very end.
  function automatic lfsc_bytes_t random_sweep();
    lfsc_bytes_t s;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 10)      s = lfsc_bytes_t'({$urandom(), 8'($urandom())});
    else if (pick < 30) s = sweep_for(PAT_ALL);
    else if (pick < 80) s = sweep_for(STEER_PATS[$urandom_range(13)]);
    else                s = sweep_for(5'($urandom_range(31)));
    if (steer_state.last_pattern == PAT_ALL && line_pattern(s) == PAT_ALL)
      s[0] = 8'h00;
    return s;
  endfunction

  task automatic set_idle_mode(input int mode);
    case (mode)
      MODE_STEADY:   begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
      MODE_SENDER:   begin sender_idle_pct = 65; recv_stall_pct = 0;  end
      MODE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 65; end
      default:       begin sender_idle_pct = 35; recv_stall_pct = 35; end
    endcase
  endtask

  // Offers one sweep and waits for the accepting edge; the predictor runs there.
  task automatic send_sweep(input lfsc_bytes_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid        = 1'b1;
    in_ch.sample_zero  = s[0];
    in_ch.sample_one   = s[1];
    in_ch.sample_two   = s[2];
    in_ch.sample_three = s[3];
    in_ch.sample_four  = s[4];
    do @(posedge clk); while (!in_ch.ready);
    expected_steer.push_back(predict_steer(s));
  endtask

  task automatic send_random(input int count);
    for (int n = 0; n < count; n++) send_sweep(random_sweep());
  endtask

  // Drops valid and waits until every predicted result has come back.
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_steer.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write; only called while the block is idle.
  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    case (idx)
      REG_THR_ZERO:  line_level[0] = value;
      REG_THR_ONE:   line_level[1] = value;
      REG_THR_TWO:   line_level[2] = value;
      REG_THR_THREE: line_level[3] = value;
      REG_THR_FOUR:  line_level[4] = value;
      REG_MASTER:    drive_level   = value;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic program_levels(input logic [7:0] levels [5], input logic [7:0] master);
    for (int i = 0; i < 5; i++) write_reg(THR_REG[i], levels[i]);
    write_reg(REG_MASTER, master);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Receiver: ready is redrawn at every falling edge from the stall percentage.
  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted result is matched against the oldest prediction.
  always @(posedge clk) begin : check_result
    steer_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_steer.size() == 0) begin
        report_mismatch("result with no sweep pending, port", out_ch.port_value, 0);
      end else begin
        want = expected_steer.pop_front();
        if (out_ch.port_value !== want.port_value)
          report_mismatch("port_value", out_ch.port_value, want.port_value);
        if (out_ch.right_drive !== want.right_drive)
          report_mismatch("right_drive", out_ch.right_drive, want.right_drive);
        if (out_ch.left_drive !== want.left_drive)
          report_mismatch("left_drive", out_ch.left_drive, want.left_drive);
        if (out_ch.stopped !== want.stopped)
          report_mismatch("stopped", out_ch.stopped, want.stopped);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset levels, every steering decode once, the wide-centre reading under each
  // remembered direction, a full loop between two nodes, an unchanged pattern,
  // an unlisted pattern and the all-zero and all-ones sweeps.
  task automatic test_directed_patterns();
    set_idle_mode(MODE_STEADY);
    send_sweep('0);                 // all white right after reset: outputs unchanged
    send_sweep(sweep_for(PAT_WIDE)); // wide centre with no turn remembered
    send_sweep(sweep_for(PAT_C));
    send_sweep(sweep_for(PAT_WIDE)); // wide centre after straight
    send_sweep(sweep_for(PAT_R1));
    send_sweep(sweep_for(PAT_WIDE)); // wide centre after a right turn
    send_sweep(sweep_for(PAT_L1));
    send_sweep(sweep_for(PAT_WIDE)); // wide centre after a left turn
    send_sweep(sweep_for(PAT_CL));
    send_sweep(sweep_for(PAT_CR));
    send_sweep(sweep_for(PAT_RC));
    send_sweep(sweep_for(PAT_LC));
    send_sweep(sweep_for(PAT_L3));
    send_sweep(sweep_for(PAT_L4));
    send_sweep(sweep_for(PAT_L2));
    send_sweep(sweep_for(PAT_R3));
    send_sweep(sweep_for(PAT_R4));
    send_sweep(sweep_for(PAT_R2));
    send_sweep('1);                 // node: enter the loop
    send_sweep(sweep_for(PAT_R2));
    send_sweep(sweep_for(PAT_ALL)); // node again: leave the loop, count a square
    send_sweep(sweep_for(PAT_C));   // exit phase shows the new count
    send_sweep(sweep_for(PAT_C));   // unchanged pattern: no decode
    send_sweep(sweep_for(5'h05));   // unlisted pattern
    wait_drained();
  endtask

  // Several register settings, extremes among them, each run under one of the idle modes in turn.
  task automatic test_register_settings();
    logic [7:0] levels [5];
    logic [7:0] master;
    int         count;
    for (int ph = 0; ph < 8; ph++) begin
      count = ITEMS_PER_SETTING;
      for (int i = 0; i < 5; i++) levels[i] = 8'($urandom_range(255));
      master = 8'($urandom_range(255));
      case (ph)
        0: begin levels = '{8'd128, 8'd180, 8'd76, 8'd76, 8'd180}; master = 8'd230; end
        1: begin levels = '{default: 8'h00}; master = 8'hFF; end
        2: begin
          // Nothing can read as line here, so a short run is enough.
          levels = '{default: 8'hFF};
          master = 8'h00;
          count  = 60;
        end
        4: begin levels = '{default: 8'hFE}; master = 8'h01; end
        5: master = 8'hFF;
        7: begin levels = '{default: 8'h01}; master = 8'd100; end
        default: ;
      endcase
      program_levels(levels, master);
      set_idle_mode(ph % 4);
      send_random(count);
      wait_drained();
    end
  endtask

  // The sender holds off until every result is back, then resumes mid-stream.
  task automatic test_drain_pause();
    set_idle_mode(MODE_BOTH);
    send_random(20);
    wait_drained();
    send_random(20);
    wait_drained();
  endtask

  // Two nodes in a row stop the block; later sweeps and register writes must
  // leave the held outputs alone.
  task automatic test_halt();
    logic [7:0] levels [5];
    levels = '{default: 8'd128};
    program_levels(levels, 8'd200);
    set_idle_mode(MODE_STEADY);
    send_sweep(sweep_for(PAT_ALL));
    send_sweep(sweep_for(PAT_ALL));
    set_idle_mode(MODE_RECEIVER);
    send_random(8);
    wait_drained();
    levels = '{default: 8'h00};
    program_levels(levels, 8'd10);
    set_idle_mode(MODE_BOTH);
    send_random(8);
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Sequencing
  // ---------------------------------------------------------------------------

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = REG_THR_ZERO;
    cfg_data           = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample_zero  = '0;
    in_ch.sample_one   = '0;
    in_ch.sample_two   = '0;
    in_ch.sample_three = '0;
    in_ch.sample_four  = '0;
    out_ch.ready       = 1'b0;

    // Predictor starts from the documented reset values.
    line_level  = '{8'd128, 8'd180, 8'd76, 8'd76, 8'd180};
    drive_level = 8'd230;
    steer_state = '0;
    steer_state.right_reg = 8'hFF;
    steer_state.left_reg  = 8'hFF;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_patterns();
    test_register_settings();
    test_drain_pause();
    test_halt();

    if (mismatch_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
